@@ rtl/core/dssv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssv_pkg
// Shared types, constants and helpers of the dual-slot save validator.
// ----------------------------------------------------------------------------
package dssv_pkg;

    // Default geometry and register reset
    localparam int unsigned SECTORS_PER_SLOT_DEF = 14;
    localparam logic [31:0] SIG_RESET            = 32'h0801_2025;

    // Slot and overall status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ERROR   = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_CORRUPT = 2'd3;

    // Input word as it travels through the input register (lowest field last)
    typedef struct packed {
        logic        end_of_scan;
        logic        slot_index;
        logic        end_of_sector;
        logic [31:0] sector_counter;
        logic [15:0] stored_checksum;
        logic [31:0] footer_signature;
        logic [15:0] sector_id;
        logic [31:0] data_word;
    } item_t;

    // Verdict word (lowest field last)
    typedef struct packed {
        logic [1:0]  second_slot_status;
        logic [1:0]  first_slot_status;
        logic [31:0] save_counter;
        logic [1:0]  overall_status;
    } verdict_t;

    localparam int unsigned ITEM_W    = $bits(item_t);
    localparam int unsigned VERDICT_W = $bits(verdict_t);
    localparam int unsigned OUT_TDATA_W = ((VERDICT_W + 7) / 8) * 8;

    // Status of one slot from its signature flag and its full-mask match
    function automatic logic [1:0] slot_state(input logic seen, input logic full);
        logic [1:0] st;
        if (!seen) begin
            st = ST_EMPTY;
        end else if (full) begin
            st = ST_OK;
        end else begin
            st = ST_ERROR;
        end
        return st;
    endfunction

    // Newest of two counters; the wrap pair all-ones / zero picks zero
    function automatic logic [31:0] newest_counter(input logic [31:0] c0,
                                                   input logic [31:0] c1);
        logic [31:0] res;
        if ((c0 == '1 && c1 == '0) || (c0 == '0 && c1 == '1)) begin
            res = '0;
        end else if (c0 < c1) begin
            res = c1;
        end else begin
            res = c0;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/dssv_slice.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssv_slice
// Register slice with a skid entry: full throughput, registered ready.
// ----------------------------------------------------------------------------
module dssv_slice
    import dssv_pkg::*;
#(
    parameter int unsigned WIDTH = ITEM_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg, valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] data_reg, data_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Main register refills from the skid entry first, else from the input
    always_comb begin
        valid_next      = valid_reg;
        data_next       = data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !valid_reg) begin
            if (skid_valid_reg) begin
                valid_next      = 1'b1;
                data_next       = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                valid_next = in_valid;
                data_next  = in_data;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        data_reg      <= data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ rtl/core/dssv_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssv_scan
// Per-word sector checksum, slot masks and counters, and the scan verdict.
// ----------------------------------------------------------------------------
module dssv_scan
    import dssv_pkg::*;
#(
    parameter int unsigned SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [31:0] cfg_wdata,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        res_valid,
    input  logic        res_ready,
    output verdict_t    res
);

    localparam int unsigned MASK_W = SECTORS_PER_SLOT + 1;
    localparam int unsigned IDX_W  = $clog2(MASK_W);
    localparam logic [MASK_W-1:0] FULL_MASK = {1'b0, {SECTORS_PER_SLOT{1'b1}}};
    localparam logic [MASK_W-1:0] STRAY_BIT = {1'b1, {SECTORS_PER_SLOT{1'b0}}};
    localparam logic [15:0] ID_LIMIT = 16'(SECTORS_PER_SLOT);

    logic [31:0]       sig_reg;
    logic [31:0]       word_sum_reg, word_sum_next;
    logic [MASK_W-1:0] mask_reg [2];
    logic [MASK_W-1:0] mask_next [2];
    logic              seen_reg [2];
    logic              seen_next [2];
    logic [31:0]       cnt_reg [2];
    logic [31:0]       cnt_next [2];

    logic              fire;
    logic [31:0]       sum_new;
    logic [15:0]       folded;
    logic              sig_hit;
    logic              sector_good;
    logic [MASK_W-1:0] id_bit;
    logic [1:0]        st0, st1;

    // Whole pipeline moves only when the result side can take a word
    assign item_ready = res_ready;
    assign fire       = item_valid && res_ready;

    // Sector checksum: running sum folded high half plus low half
    assign sum_new     = word_sum_reg + item.data_word;
    assign folded      = sum_new[31:16] + sum_new[15:0];
    assign sig_hit     = item.end_of_sector && (item.footer_signature == sig_reg);
    assign sector_good = sig_hit && (item.stored_checksum == folded);
    assign id_bit      = (item.sector_id < ID_LIMIT)
                       ? (MASK_W'(1) << item.sector_id[IDX_W-1:0]) : STRAY_BIT;

    // Slot state after this word
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            mask_next[s] = mask_reg[s];
            seen_next[s] = seen_reg[s];
            cnt_next[s]  = cnt_reg[s];
            if (item.slot_index == 1'(s)) begin
                if (sig_hit) begin
                    seen_next[s] = 1'b1;
                end
                if (sector_good) begin
                    mask_next[s] = mask_reg[s] | id_bit;
                    cnt_next[s]  = item.sector_counter;
                end
            end
        end
        word_sum_next = (item.end_of_sector || item.end_of_scan) ? '0 : sum_new;
    end

    // Verdict from the state including this word
    assign st0 = slot_state(seen_next[0], mask_next[0] == FULL_MASK);
    assign st1 = slot_state(seen_next[1], mask_next[1] == FULL_MASK);

    always_comb begin
        res.first_slot_status  = st0;
        res.second_slot_status = st1;
        if (st0 == ST_OK && st1 == ST_OK) begin
            res.save_counter   = newest_counter(cnt_next[0], cnt_next[1]);
            res.overall_status = ST_OK;
        end else if (st0 == ST_OK) begin
            res.save_counter   = cnt_next[0];
            res.overall_status = (st1 == ST_ERROR) ? ST_ERROR : ST_OK;
        end else if (st1 == ST_OK) begin
            res.save_counter   = cnt_next[1];
            res.overall_status = (st0 == ST_ERROR) ? ST_ERROR : ST_OK;
        end else if (st0 == ST_EMPTY && st1 == ST_EMPTY) begin
            res.save_counter   = '0;
            res.overall_status = ST_EMPTY;
        end else begin
            res.save_counter   = '0;
            res.overall_status = ST_CORRUPT;
        end
    end

    assign res_valid = item_valid && item.end_of_scan;

    // State registers; a scan end clears masks, flags and the sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg      <= SIG_RESET;
            word_sum_reg <= '0;
            for (int s = 0; s < 2; s++) begin
                mask_reg[s] <= '0;
                seen_reg[s] <= 1'b0;
            end
        end else begin
            if (cfg_wen) begin
                sig_reg <= cfg_wdata;
            end
            if (fire) begin
                word_sum_reg <= word_sum_next;
                for (int s = 0; s < 2; s++) begin
                    mask_reg[s] <= item.end_of_scan ? '0 : mask_next[s];
                    seen_reg[s] <= item.end_of_scan ? 1'b0 : seen_next[s];
                end
            end
        end
        // Counters are only read for an ok slot, which wrote them this scan
        if (fire) begin
            for (int s = 0; s < 2; s++) begin
                cnt_reg[s] <= cnt_next[s];
            end
        end
    end

    // Scan end leaves no slot state behind
    a_scan_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_of_scan |=> !seen_reg[0] && !seen_reg[1]
            && mask_reg[0] == '0 && mask_reg[1] == '0 && word_sum_reg == '0)
        else $error("slot state not cleared after scan end");

    // A finished sector restarts the running sum
    a_sector_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.end_of_sector |=> word_sum_reg == '0)
        else $error("sector sum not restarted");

    // Empty verdict needs both slots empty and a zero counter
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.overall_status == ST_EMPTY |->
            st0 == ST_EMPTY && st1 == ST_EMPTY && res.save_counter == '0)
        else $error("inconsistent empty verdict");

    // Corrupt verdict means no slot is ok
    a_corrupt: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.overall_status == ST_CORRUPT |->
            st0 != ST_OK && st1 != ST_OK && res.save_counter == '0)
        else $error("inconsistent corrupt verdict");

endmodule

@@ rtl/core/dual_slot_save_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_slot_save_validator
// A/B save slot validation with a sequence counter over a flash word stream.
// ----------------------------------------------------------------------------
// Takes one 32-bit data word per clock, with sector footer fields on the last
// word of each sector, and keeps taking one word per clock while the verdict
// port is stalled, until the skid entries of the two register slices fill.
// A word passes the input register, then the checksum, mask and verdict logic
// into the output register, from which the verdict goes out on the master side.
// The slot masks, signature flags and running sum are cleared by the scan
// end word, so the next scan may follow in the very next cycle. The user
// must write the signature register through cfg_wen/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
module dual_slot_save_validator
    import dssv_pkg::*;
#(
    parameter int unsigned SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Signature register write
    input  logic                   cfg_wen,
    input  logic [31:0]            cfg_wdata,
    // Input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // data_word[31:0], sector_id[47:32], footer_signature[79:48],
    // stored_checksum[95:80], sector_counter[127:96]
    input  logic [127:0]           s_axis_tdata,
    // end_of_sector[0], slot_index[1]
    input  logic [1:0]             s_axis_tuser,
    // end_of_scan
    input  logic                   s_axis_tlast,
    // Verdict words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // overall_status[1:0], save_counter[33:2], first_slot_status[35:34],
    // second_slot_status[37:36], zero pad above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    item_t    in_word;
    item_t    item;
    logic     item_valid, item_ready;
    verdict_t res;
    logic     res_valid, res_ready;
    logic [VERDICT_W-1:0] out_word;

    // Unpack the input word
    always_comb begin
        in_word.data_word        = s_axis_tdata[31:0];
        in_word.sector_id        = s_axis_tdata[47:32];
        in_word.footer_signature = s_axis_tdata[79:48];
        in_word.stored_checksum  = s_axis_tdata[95:80];
        in_word.sector_counter   = s_axis_tdata[127:96];
        in_word.end_of_sector    = s_axis_tuser[0];
        in_word.slot_index       = s_axis_tuser[1];
        in_word.end_of_scan      = s_axis_tlast;
    end

    // Input register
    dssv_slice #(
        .WIDTH (ITEM_W)
    ) u_in_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_word),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_data  (item)
    );

    // Sector checks and verdict
    dssv_scan #(
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register
    dssv_slice #(
        .WIDTH (VERDICT_W)
    ) u_out_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_word)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_word);

endmodule
